// ===== hdl/pdlf_pkg.sv =====
// package: widths, fault window, register indexes and constants of the line follower
package pdlf_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int DIST_BITS   = 24;
    localparam int GAIN_BITS   = 16;
    localparam int SPEED_BITS  = 8;
    localparam int ERR_BITS    = SAMPLE_BITS + 1;
    localparam int DERIV_BITS  = SAMPLE_BITS + 2;
    localparam int PTERM_BITS  = GAIN_BITS + ERR_BITS;
    localparam int DTERM_BITS  = GAIN_BITS + DERIV_BITS;
    localparam int PD_BITS     = DTERM_BITS + 1;
    localparam int FRAC_BITS   = 8;
    localparam int CTL_BITS    = PD_BITS - FRAC_BITS;
    localparam int DRV_BITS    = CTL_BITS + 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = DIST_BITS;

    localparam logic [SAMPLE_BITS-1:0] FAULT_LOW  = SAMPLE_BITS'(100);
    localparam logic [SAMPLE_BITS-1:0] FAULT_HIGH = SAMPLE_BITS'(1000);

    // floor(x / 10) = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x below 2^32
    localparam int RGB_BITS    = DIST_BITS + 3;
    localparam int RECIP_BITS  = 32;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_BITS-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam logic [CFG_IDX_BITS-1:0] REG_PROP_GAIN     = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_DERIV_GAIN    = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP_SPEED     = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_DROP_DISTANCE = CFG_IDX_BITS'(3);

    localparam logic signed [GAIN_BITS-1:0] PROP_GAIN_RESET  = GAIN_BITS'(256);
    localparam logic signed [GAIN_BITS-1:0] DERIV_GAIN_RESET = GAIN_BITS'(0);
    localparam logic [SPEED_BITS-1:0]       TOP_SPEED_RESET  = SPEED_BITS'(255);
    localparam logic [DIST_BITS-1:0]        DROP_DIST_RESET  = DIST_BITS'(10000);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic                   drop_check;
        logic                   force_drop;
    } t_in_word;

    typedef struct packed {
        logic                  sensors_ok;
        logic                  left_fault;
        logic                  right_fault;
        logic [SPEED_BITS-1:0] left_speed;
        logic [SPEED_BITS-1:0] right_speed;
        logic                  released;
        logic                  dropped_flag;
    } t_out_word;

endpackage

// ===== hdl/pdlf_if.sv =====
// interfaces: sample input, result output and configuration write channels
interface pdlf_in_if;
    logic                             valid;
    logic                             ready;
    logic [pdlf_pkg::SAMPLE_BITS-1:0] left_sample;
    logic [pdlf_pkg::SAMPLE_BITS-1:0] right_sample;
    logic                             drop_check;
    logic                             force_drop;

    modport source (output valid, output left_sample, output right_sample,
                    output drop_check, output force_drop, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input drop_check, input force_drop, output ready);
endinterface

interface pdlf_out_if;
    logic                            valid;
    logic                            ready;
    logic                            sensors_ok;
    logic                            left_fault;
    logic                            right_fault;
    logic [pdlf_pkg::SPEED_BITS-1:0] left_speed;
    logic [pdlf_pkg::SPEED_BITS-1:0] right_speed;
    logic                            released;
    logic                            dropped_flag;

    modport source (output valid, output sensors_ok, output left_fault, output right_fault,
                    output left_speed, output right_speed, output released,
                    output dropped_flag, input ready);
    modport sink   (input valid, input sensors_ok, input left_fault, input right_fault,
                    input left_speed, input right_speed, input released,
                    input dropped_flag, output ready);
endinterface

interface pdlf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pdlf_pkg::CFG_IDX_BITS-1:0]  index;
    logic [pdlf_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pd_line_follower_with_dispenser.sv =====
// top level: pd line follower with distance based dispenser control
//
//   channel  | dir | word
//   i_in     | in  | left_sample, right_sample, drop_check, force_drop
//   o_out    | out | sensors_ok, left_fault, right_fault, left_speed, right_speed,
//            |     | released, dropped_flag
//   i_cfg    | in  | index, data (always ready)
//
// one word per cycle sustained while the result is taken (o_out.ready)
// input register, then the pd step and state update land in the result register
// synchronous active low reset loads the register defaults and clears the state registers and valid flags
// a stalled result holds; the input register takes one more word, then input ready drops
module pd_line_follower_with_dispenser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pdlf_in_if.sink        i_in,
    pdlf_out_if.source     o_out,
    pdlf_cfg_if.sink       i_cfg
);

    logic                                   r_in_valid;
    pdlf_pkg::t_in_word                     r_in;
    logic                                   r_out_valid;
    pdlf_pkg::t_out_word                    r_out;
    pdlf_pkg::t_out_word                    n_out;

    logic signed [pdlf_pkg::GAIN_BITS-1:0]  r_prop_gain;
    logic signed [pdlf_pkg::GAIN_BITS-1:0]  r_deriv_gain;
    logic [pdlf_pkg::SPEED_BITS-1:0]        r_top_speed;
    logic [pdlf_pkg::DIST_BITS-1:0]         r_drop_distance;
    logic [pdlf_pkg::DIST_BITS-1:0]         r_regrab;
    logic [pdlf_pkg::DIST_BITS-1:0]         n_regrab;

    logic signed [pdlf_pkg::ERR_BITS-1:0]   r_prev_error;
    logic [pdlf_pkg::DIST_BITS-1:0]         r_travel;
    logic [pdlf_pkg::SPEED_BITS-1:0]        r_left_drive;
    logic [pdlf_pkg::SPEED_BITS-1:0]        r_right_drive;
    logic                                   r_is_released;
    logic                                   r_drop_state;

    logic signed [pdlf_pkg::ERR_BITS-1:0]   n_prev_error;
    logic [pdlf_pkg::DIST_BITS-1:0]         n_travel;
    logic [pdlf_pkg::SPEED_BITS-1:0]        n_left_drive;
    logic [pdlf_pkg::SPEED_BITS-1:0]        n_right_drive;
    logic                                   n_is_released;
    logic                                   n_drop_state;

    logic                                   advance;
    logic                                   left_fault;
    logic                                   right_fault;
    logic                                   ok;
    logic signed [pdlf_pkg::ERR_BITS-1:0]   err;
    logic signed [pdlf_pkg::DERIV_BITS-1:0] deriv;
    logic signed [pdlf_pkg::PTERM_BITS-1:0] p_term;
    logic signed [pdlf_pkg::DTERM_BITS-1:0] d_term;
    logic signed [pdlf_pkg::PD_BITS-1:0]    pd_sum;
    logic signed [pdlf_pkg::CTL_BITS-1:0]   ctl;
    logic signed [pdlf_pkg::DRV_BITS-1:0]   top_ext;
    logic signed [pdlf_pkg::DRV_BITS-1:0]   left_raw;
    logic signed [pdlf_pkg::DRV_BITS-1:0]   right_raw;
    logic [pdlf_pkg::SPEED_BITS-1:0]        left_clamp;
    logic [pdlf_pkg::SPEED_BITS-1:0]        right_clamp;
    logic [pdlf_pkg::DIST_BITS:0]           travel_sum;
    logic [pdlf_pkg::DIST_BITS-1:0]         travel_sat;
    logic [pdlf_pkg::RGB_BITS-1:0]          dist_x7;
    logic [pdlf_pkg::RGB_BITS+pdlf_pkg::RECIP_BITS-1:0] regrab_prod;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= pdlf_pkg::PROP_GAIN_RESET;
            r_deriv_gain    <= pdlf_pkg::DERIV_GAIN_RESET;
            r_top_speed     <= pdlf_pkg::TOP_SPEED_RESET;
            r_drop_distance <= pdlf_pkg::DROP_DIST_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pdlf_pkg::REG_PROP_GAIN: begin
                    r_prop_gain <= i_cfg.data[pdlf_pkg::GAIN_BITS-1:0];
                end
                pdlf_pkg::REG_DERIV_GAIN: begin
                    r_deriv_gain <= i_cfg.data[pdlf_pkg::GAIN_BITS-1:0];
                end
                pdlf_pkg::REG_TOP_SPEED: begin
                    r_top_speed <= i_cfg.data[pdlf_pkg::SPEED_BITS-1:0];
                end
                pdlf_pkg::REG_DROP_DISTANCE: begin
                    r_drop_distance <= i_cfg.data[pdlf_pkg::DIST_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // regrab threshold floor(7 * drop_distance / 10), refreshed every cycle
    always_comb begin
        dist_x7     = (pdlf_pkg::RGB_BITS'(r_drop_distance) << 3)
                    - pdlf_pkg::RGB_BITS'(r_drop_distance);
        regrab_prod = (pdlf_pkg::RGB_BITS + pdlf_pkg::RECIP_BITS)'(dist_x7)
                    * (pdlf_pkg::RGB_BITS + pdlf_pkg::RECIP_BITS)'(pdlf_pkg::RECIP_TEN);
        n_regrab    = pdlf_pkg::DIST_BITS'(regrab_prod >> pdlf_pkg::RECIP_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        r_regrab <= n_regrab;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.left_sample  <= i_in.left_sample;
            r_in.right_sample <= i_in.right_sample;
            r_in.drop_check   <= i_in.drop_check;
            r_in.force_drop   <= i_in.force_drop;
        end
    end

    // pd step
    always_comb begin
        left_fault  = (r_in.left_sample > pdlf_pkg::FAULT_LOW)
                   && (r_in.left_sample < pdlf_pkg::FAULT_HIGH);
        right_fault = (r_in.right_sample > pdlf_pkg::FAULT_LOW)
                   && (r_in.right_sample < pdlf_pkg::FAULT_HIGH);
        ok          = !left_fault && !right_fault;

        err    = $signed({1'b0, r_in.left_sample}) - $signed({1'b0, r_in.right_sample});
        deriv  = pdlf_pkg::DERIV_BITS'(err) - pdlf_pkg::DERIV_BITS'(r_prev_error);
        p_term = pdlf_pkg::PTERM_BITS'(r_prop_gain) * pdlf_pkg::PTERM_BITS'(err);
        d_term = pdlf_pkg::DTERM_BITS'(r_deriv_gain) * pdlf_pkg::DTERM_BITS'(deriv);
        pd_sum = pdlf_pkg::PD_BITS'(p_term) + pdlf_pkg::PD_BITS'(d_term);
        ctl    = pdlf_pkg::CTL_BITS'(pd_sum >>> pdlf_pkg::FRAC_BITS);

        top_ext   = $signed({{(pdlf_pkg::DRV_BITS-pdlf_pkg::SPEED_BITS){1'b0}}, r_top_speed});
        left_raw  = top_ext - pdlf_pkg::DRV_BITS'(ctl);
        right_raw = top_ext + pdlf_pkg::DRV_BITS'(ctl);

        if (left_raw < 0) begin
            left_clamp = '0;
        end else if (left_raw > top_ext) begin
            left_clamp = r_top_speed;
        end else begin
            left_clamp = pdlf_pkg::SPEED_BITS'(left_raw);
        end
        if (right_raw < 0) begin
            right_clamp = '0;
        end else if (right_raw > top_ext) begin
            right_clamp = r_top_speed;
        end else begin
            right_clamp = pdlf_pkg::SPEED_BITS'(right_raw);
        end

        travel_sum = (pdlf_pkg::DIST_BITS+1)'(r_travel)
                   + (pdlf_pkg::DIST_BITS+1)'(left_clamp)
                   + (pdlf_pkg::DIST_BITS+1)'(right_clamp);
        travel_sat = travel_sum[pdlf_pkg::DIST_BITS] ? '1
                   : travel_sum[pdlf_pkg::DIST_BITS-1:0];

        n_prev_error  = r_prev_error;
        n_travel      = r_travel;
        n_left_drive  = r_left_drive;
        n_right_drive = r_right_drive;
        n_is_released = r_is_released;
        n_drop_state  = r_drop_state;

        if (ok) begin
            n_prev_error  = err;
            n_left_drive  = left_clamp;
            n_right_drive = right_clamp;
            n_travel      = travel_sat;
            if (r_in.drop_check) begin
                if (!r_is_released && (travel_sat >= r_drop_distance || r_in.force_drop)) begin
                    n_is_released = 1'b1;
                    n_drop_state  = 1'b1;
                    n_travel      = '0;
                end else if (r_is_released && (travel_sat >= r_regrab || r_in.force_drop)) begin
                    n_is_released = 1'b0;
                    n_drop_state  = 1'b0;
                end
            end
        end

        n_out.sensors_ok   = ok;
        n_out.left_fault   = left_fault;
        n_out.right_fault  = right_fault;
        n_out.left_speed   = n_left_drive;
        n_out.right_speed  = n_right_drive;
        n_out.released     = n_is_released;
        n_out.dropped_flag = n_drop_state;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error  <= '0;
            r_travel      <= '0;
            r_left_drive  <= '0;
            r_right_drive <= '0;
            r_is_released <= 1'b0;
            r_drop_state  <= 1'b0;
        end else if (advance) begin
            r_prev_error  <= n_prev_error;
            r_travel      <= n_travel;
            r_left_drive  <= n_left_drive;
            r_right_drive <= n_right_drive;
            r_is_released <= n_is_released;
            r_drop_state  <= n_drop_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sensors_ok   = r_out.sensors_ok;
    assign o_out.left_fault   = r_out.left_fault;
    assign o_out.right_fault  = r_out.right_fault;
    assign o_out.left_speed   = r_out.left_speed;
    assign o_out.right_speed  = r_out.right_speed;
    assign o_out.released     = r_out.released;
    assign o_out.dropped_flag = r_out.dropped_flag;

endmodule

// ===== hdl/pdlf_checker.sv =====
// checker: port level assertions for the line follower, bound to the top level
module pdlf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic                            i_sensors_ok,
    input logic                            i_left_fault,
    input logic                            i_right_fault,
    input logic [pdlf_pkg::SPEED_BITS-1:0] i_left_speed,
    input logic [pdlf_pkg::SPEED_BITS-1:0] i_right_speed,
    input logic                            i_released,
    input logic                            i_dropped_flag
);

    // ok flag agrees with the two fault flags
    a_ok_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sensors_ok == !(i_left_fault || i_right_fault)))
        else $error("sensors_ok disagrees with fault flags");

    // dispenser position and decision flag move together
    a_drop_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_released == i_dropped_flag))
        else $error("released and dropped_flag differ");

    // an empty result register never blocks the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !i_out_valid) |-> i_in_ready)
        else $error("input stalled with no pending result");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_left_speed)
            && $stable(i_right_speed) && $stable(i_released) && $stable(i_sensors_ok)))
        else $error("stalled result word changed");

endmodule

bind pd_line_follower_with_dispenser pdlf_checker u_pdlf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_sensors_ok   (o_out.sensors_ok),
    .i_left_fault   (o_out.left_fault),
    .i_right_fault  (o_out.right_fault),
    .i_left_speed   (o_out.left_speed),
    .i_right_speed  (o_out.right_speed),
    .i_released     (o_out.released),
    .i_dropped_flag (o_out.dropped_flag)
);
